@@ rtl/assert_macros.svh @@
// Assertion macros used by the top-level unit.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

@@ rtl/pbc_pkg.sv @@
// Package for the plaquette Berry-phase Chern unit: widths, constants, CORDIC table.
// No dependencies.
package pbc_pkg;
  localparam int AccW = 48;
  localparam int CordicSteps = 16;
  localparam int StepsUsed = (CordicSteps > 24) ? 24 : CordicSteps;
  localparam int StepW = $clog2(StepsUsed + 1);
  localparam logic signed [17:0] HalfTurn = 18'sd32768;
  localparam logic signed [17:0] QuarterTurn = 18'sd16384;

  typedef logic signed [AccW-1:0] acc_t;

  // Arctangent of two to the minus i, in Q.16 turns.
  function automatic logic signed [17:0] atan_turns(input logic [4:0] i);
    logic signed [17:0] a;
    case (i)
      5'd0: a = 18'sd8192;
      5'd1: a = 18'sd4836;
      5'd2: a = 18'sd2555;
      5'd3: a = 18'sd1297;
      5'd4: a = 18'sd651;
      5'd5: a = 18'sd326;
      5'd6: a = 18'sd163;
      5'd7: a = 18'sd81;
      5'd8: a = 18'sd41;
      5'd9: a = 18'sd20;
      5'd10: a = 18'sd10;
      5'd11: a = 18'sd5;
      5'd12: a = 18'sd3;
      5'd13: a = 18'sd1;
      5'd14: a = 18'sd1;
      default: a = 18'sd0;
    endcase
    return a;
  endfunction
endpackage

@@ rtl/pbc_lane.sv @@
// One overlap lane: saturating conjugate dot-product accumulator.
// Depends on pbc_pkg.
module pbc_lane import pbc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               clr,
  input  logic signed [15:0] xr,
  input  logic signed [15:0] xi,
  input  logic signed [15:0] yr,
  input  logic signed [15:0] yi,
  output acc_t               acc_re,
  output acc_t               acc_im
);
  acc_t re_r, im_r, re_nxt, im_nxt;
  logic signed [31:0] p_rr, p_ii, p_ri, p_ir;

  // Saturating add of one product pair to a 48-bit accumulator.
  function automatic acc_t sat_add(acc_t a, logic signed [33:0] p);
    logic signed [AccW:0] s;
    s = $signed({a[AccW-1], a}) + (AccW+1)'(p);
    if (s[AccW] != s[AccW-1]) return s[AccW] ? {1'b1, {(AccW-1){1'b0}}}
                                             : {1'b0, {(AccW-1){1'b1}}};
    return s[AccW-1:0];
  endfunction

  // Full-width 16x16 products, then the conjugate sums.
  always_comb begin
    p_rr = xr * yr;
    p_ii = xi * yi;
    p_ri = xr * yi;
    p_ir = xi * yr;
    re_nxt = sat_add(re_r, 34'(p_rr) + 34'(p_ii));
    im_nxt = sat_add(im_r, 34'(p_ri) - 34'(p_ir));
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      re_r <= '0;
      im_r <= '0;
    end else if (en) begin
      re_r <= re_nxt;
      im_r <= im_nxt;
    end
  end

  assign acc_re = re_r;
  assign acc_im = im_r;
endmodule

@@ rtl/pbc_cordic.sv @@
// Iterative CORDIC vectoring unit giving the phase of a 48-bit vector in Q.16 turns.
// Depends on pbc_pkg.
module pbc_cordic import pbc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  acc_t               x_in,
  input  acc_t               y_in,
  output logic               done,
  output logic signed [17:0] phase
);
  logic signed [AccW+1:0] x_r, y_r;
  logic signed [17:0] z_r;
  logic [StepW-1:0] i_r;
  logic busy_r, done_r;
  logic signed [AccW+1:0] dx, dy;

  assign dx = y_r >>> i_r;
  assign dy = x_r >>> i_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        i_r <= '0;
        // Rotate the left half plane onto the right one first.
        if (x_in < 0) begin
          if (y_in >= 0) begin
            x_r <= (AccW+2)'(y_in); y_r <= -(AccW+2)'(x_in); z_r <= QuarterTurn;
          end else begin
            x_r <= -(AccW+2)'(y_in); y_r <= (AccW+2)'(x_in); z_r <= -QuarterTurn;
          end
        end else begin
          x_r <= (AccW+2)'(x_in); y_r <= (AccW+2)'(y_in); z_r <= '0;
        end
      end else if (busy_r) begin
        if (y_r > 0) begin
          x_r <= x_r + dx; y_r <= y_r - dy; z_r <= z_r + atan_turns(5'(i_r));
        end else if (y_r < 0) begin
          x_r <= x_r - dx; y_r <= y_r + dy; z_r <= z_r - atan_turns(5'(i_r));
        end
        if (i_r == StepW'(StepsUsed - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          i_r <= i_r + 1'b1;
        end
      end
    end
  end

  assign done  = done_r;
  assign phase = z_r;
endmodule

@@ rtl/plaquette_berry_phase_chern_unit.sv @@
// Plaquette Berry-phase Chern unit: four overlap lanes, shared CORDIC, merge stage.
// Depends on pbc_pkg, pbc_lane, pbc_cordic and assert_macros.svh.
// Throughput: one beat per cycle for components that do not close a plaquette.
// A closing beat blocks the input while the one CORDIC serves the four overlaps in turn and
// the merge stage runs; after a last plaquette it stays blocked until the result is taken.
// Reset (synchronous, rst_n low) clears accumulators and sets state_offset to 256.
`include "assert_macros.svh"
module plaquette_berry_phase_chern_unit import pbc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // corner00_re, corner00_im, corner10_re, corner10_im,
  // corner11_re, corner11_im, corner01_re, corner01_im
  input  logic [127:0] in_tdata,
  input  logic        in_tlast,   // last_component
  input  logic [1:0]  in_tuser,   // last_plaquette, last_state
  output logic        out_tvalid,
  input  logic        out_tready,
  // chern_number, chern_nonzero, sample_done, total_chern, total_error, zero fill
  output logic [31:0] out_tdata,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);
  typedef enum logic [2:0] {S_RUN, S_START, S_WAIT, S_MERGE, S_OUT} st_t;
  st_t st_r;
  logic [15:0] off_r;
  logic [1:0] k_r;
  logic lp_r, ls_r;
  logic signed [19:0] psum_r;
  logic signed [31:0] sps_r;
  logic signed [39:0] smp_r;
  logic [31:0] out_r;
  logic acc_en, acc_clr, c_done;
  logic signed [15:0] f [8];
  acc_t re [4], im [4];
  logic signed [17:0] c_phase;

  for (genvar g = 0; g < 8; g++) begin : g_f
    assign f[g] = in_tdata[16*g +: 16];
  end

  assign in_tready = (st_r == S_RUN);
  assign acc_en = in_tvalid && in_tready;
  assign acc_clr = (st_r == S_MERGE);

  for (genvar g = 0; g < 4; g++) begin : g_lane
    pbc_lane u_lane (
      .clk(clk), .rst_n(rst_n), .en(acc_en), .clr(acc_clr),
      .xr(f[2*g]), .xi(f[2*g+1]), .yr(f[(2*g+2)%8]), .yi(f[(2*g+3)%8]),
      .acc_re(re[g]), .acc_im(im[g])
    );
  end

  pbc_cordic u_cordic (
    .clk(clk), .rst_n(rst_n), .start(st_r == S_START),
    .x_in(re[k_r]), .y_in(im[k_r]), .done(c_done), .phase(c_phase)
  );

  // Merge stage arithmetic.
  logic signed [19:0] wrapped;
  logic signed [32:0] sps_sum;
  logic signed [31:0] sps_nxt;
  logic signed [32:0] value;
  logic signed [40:0] smp_sum;
  logic signed [39:0] smp_nxt;
  logic signed [16:0] chern_q;
  logic signed [11:0] chern;
  logic signed [24:0] tot_q;
  logic signed [15:0] total;

  always_comb begin
    // Four phases can add up to a little over two turns either way.
    wrapped = psum_r;
    if (psum_r > 20'sd98304) wrapped = psum_r - 20'sd131072;
    else if (psum_r > 20'sd32768) wrapped = psum_r - 20'sd65536;
    else if (psum_r < -20'sd98304) wrapped = psum_r + 20'sd131072;
    else if (psum_r < -20'sd32768) wrapped = psum_r + 20'sd65536;
    sps_sum = 33'(sps_r) + 33'(wrapped);
    if (sps_sum > 33'sh07fffffff) sps_nxt = 32'sh7fffffff;
    else if (sps_sum < -33'sh080000000) sps_nxt = 32'sh80000000;
    else sps_nxt = sps_sum[31:0];
    value = 33'(sps_nxt) + $signed({17'd0, off_r});
    chern_q = 17'((value + 33'sd32768) >>> 16);
    if (chern_q > 17'sd1024) chern = 12'sd1024;
    else if (chern_q < -17'sd1024) chern = -12'sd1024;
    else chern = chern_q[11:0];
    smp_sum = 41'(smp_r) + 41'(value);
    if (smp_sum > 41'sh07fffffffff) smp_nxt = 40'sh7fffffffff;
    else if (smp_sum < -41'sh08000000000) smp_nxt = 40'sh8000000000;
    else smp_nxt = smp_sum[39:0];
    tot_q = 25'((42'(smp_nxt) + 42'sd32768) >>> 16);
    if (tot_q > 25'sd32767) total = 16'sh7fff;
    else if (tot_q < -25'sd32768) total = 16'sh8000;
    else total = tot_q[15:0];
  end

  // Control sequencer and registered result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_RUN;
      off_r <= 16'd256;
      sps_r <= '0;
      smp_r <= '0;
      k_r <= '0;
    end else begin
      if (cfg_we) off_r <= cfg_wdata;
      unique case (st_r)
        S_RUN: if (acc_en && in_tlast) begin
          lp_r <= in_tuser[0];
          ls_r <= in_tuser[1];
          k_r <= '0;
          psum_r <= '0;
          st_r <= S_START;
        end
        S_START: st_r <= S_WAIT;
        S_WAIT: if (c_done) begin
          psum_r <= psum_r + ((re[k_r] == '0 && im[k_r] == '0) ? 20'sd0 : 20'(c_phase));
          k_r <= k_r + 1'b1;
          st_r <= (k_r == 2'd3) ? S_MERGE : S_START;
        end
        S_MERGE: begin
          if (lp_r) begin
            sps_r <= '0;
            smp_r <= ls_r ? '0 : smp_nxt;
            out_r <= {1'b0, ls_r && (total != 16'sd1), ls_r ? total : 16'sd0,
                      ls_r, chern != 12'sd0, chern};
            st_r <= S_OUT;
          end else begin
            sps_r <= sps_nxt;
            st_r <= S_RUN;
          end
        end
        S_OUT: if (out_tready) st_r <= S_RUN;
        default: st_r <= S_RUN;
      endcase
    end
  end

  assign out_tvalid = (st_r == S_OUT);
  assign out_tdata = out_r;

  `ASSERT_IMPL(a_no_in_busy, clk, rst_n, st_r != S_RUN, !in_tready)
  `ASSERT_NEXT(a_out_after_merge, clk, rst_n, st_r == S_MERGE && lp_r, out_tvalid)
  `ASSERT_IMPL(a_total_zero, clk, rst_n, out_tvalid && !out_r[13], out_r[29:14] == 16'd0)
endmodule

@@ dv/testbench.sv @@
// Self-checking testbench for plaquette_berry_phase_chern_unit.
// Predicts each Chern result from the input beats and compares each result word as a whole.
// Depends on pbc_pkg and the unit's RTL.
`timescale 1ns / 100ps
module testbench;
  import pbc_pkg::*;

  typedef struct packed {
    logic               total_error;
    logic signed [15:0] total_chern;
    logic               sample_done;
    logic               chern_nonzero;
    logic signed [11:0] chern_number;
  } chern_result_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [127:0] in_tdata = '0;
  logic         in_tlast = 1'b0;
  logic [1:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [31:0]  out_tdata;
  logic         cfg_we = 1'b0;
  logic [15:0]  cfg_wdata = '0;

  plaquette_berry_phase_chern_unit dut (.*);

  always #2 clk = ~clk;

  // Predictor state, kept separately from the block.
  longint        overlap_sum [8];
  longint        phase_total;
  longint        sample_total;
  longint        offset_turns;
  chern_result_t pending_results[$];
  int            failures = 0;
  int            sender_idle_pct = 0;
  int            receiver_stall_pct = 0;
  int            hold_off_cycles = 0;
  int            beats_sent = 0;

  function automatic longint floor_div16(longint v);
    return v >>> 16;
  endfunction

  function automatic longint limit(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // Vectoring CORDIC in Q.16 turns, with the negative half plane pre-rotated.
  function automatic longint overlap_phase(longint x, longint y);
    longint z, t, dx, dy;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = 16384;
      end else begin
        x = -y; y = t; z = -16384;
      end
    end
    for (int i = 0; i < StepsUsed; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx; y -= dy; z += longint'(atan_turns(i[4:0]));
      end else if (y < 0) begin
        x -= dx; y += dy; z -= longint'(atan_turns(i[4:0]));
      end
    end
    return z;
  endfunction

  task automatic predict_beat(input logic [127:0] data, input logic last_comp,
                              input logic [1:0] flags);
    longint c [8];
    longint lim, ph, val, cn, tot;
    int     a, b;
    chern_result_t r;
    lim = 64'sd1 <<< 47;
    for (int i = 0; i < 8; i++) c[i] = longint'($signed(data[16*i +: 16]));
    // Lane k pairs corner k with the next corner around the loop.
    for (int k = 0; k < 4; k++) begin
      a = 2 * k;
      b = 2 * ((k + 1) % 4);
      overlap_sum[a] = limit(overlap_sum[a] + c[a] * c[b] + c[a+1] * c[b+1], -lim, lim - 1);
      overlap_sum[a+1] = limit(overlap_sum[a+1] + c[a] * c[b+1] - c[a+1] * c[b],
                               -lim, lim - 1);
    end
    if (!last_comp) return;
    ph = 0;
    for (int k = 0; k < 4; k++) ph += overlap_phase(overlap_sum[2*k], overlap_sum[2*k+1]);
    for (int i = 0; i < 8; i++) overlap_sum[i] = 0;
    while (ph > 32768) ph -= 65536;
    while (ph < -32768) ph += 65536;
    phase_total = limit(phase_total + ph, -(64'sd1 <<< 31), (64'sd1 <<< 31) - 1);
    if (!flags[0]) return;
    val = phase_total + offset_turns;
    phase_total = 0;
    cn = limit(floor_div16(val + 32768), -1024, 1024);
    sample_total = limit(sample_total + val, -(64'sd1 <<< 39), (64'sd1 <<< 39) - 1);
    r = '0;
    r.chern_number = cn[11:0];
    r.chern_nonzero = (cn != 0);
    if (flags[1]) begin
      tot = limit(floor_div16(sample_total + 32768), -32768, 32767);
      sample_total = 0;
      r.sample_done = 1'b1;
      r.total_chern = tot[15:0];
      r.total_error = (tot != 1);
    end
    pending_results.push_back(r);
  endtask

  // Sends one beat and records its expected result once accepted.
  // The valid stays high after the beat; idle gaps and drain lower it.
  task automatic send_beat(input logic [127:0] data, input logic last_comp,
                           input logic [1:0] flags);
    while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= data;
    in_tlast <= last_comp;
    in_tuser <= flags;
    do @(posedge clk); while (!in_tready);
    predict_beat(data, last_comp, flags);
    beats_sent++;
  endtask

  // Waits for the pipeline to drain; a closing beat with no result may still be in flight.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic write_offset(input logic [15:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    offset_turns = longint'(v);
  endtask

  function automatic logic [127:0] random_data(input int scale);
    logic [127:0] d;
    for (int i = 0; i < 8; i++) begin
      if (scale == 0) d[16*i +: 16] = 16'($urandom);
      else d[16*i +: 16] = 16'($urandom_range(2 * scale) - scale);
    end
    return d;
  endfunction

  // One plaquette of random content with a well-formed close.
  task automatic send_plaquette(input int comps, input logic last_plaq, input logic last_st);
    for (int i = 0; i < comps; i++)
      send_beat(random_data(($urandom_range(3) == 0) ? 0 : 12000), i == comps - 1,
                {last_st, last_plaq});
  endtask

  task automatic send_state(input logic last_st);
    int plaqs;
    plaqs = $urandom_range(1, 4);
    for (int p = 0; p < plaqs; p++) send_plaquette($urandom_range(1, 4), p == plaqs - 1, last_st);
  endtask

  // Directed corners: zero overlaps, negative real axis, full scale, stray flags.
  task automatic test_directed();
    logic [127:0] d;
    send_beat('0, 1'b1, 2'b11);
    d = {8{16'h8000}};
    send_beat(d, 1'b1, 2'b01);
    d = {8{16'h7fff}};
    send_beat(d, 1'b1, 2'b11);
    // Corners 00 and 10 opposite on the real axis give a negative overlap.
    d = '0;
    d[15:0] = 16'h4000; d[31:16] = 16'h0000; d[47:32] = 16'hc000;
    send_beat(d, 1'b1, 2'b01);
    send_beat({16'h7fff, 16'h8000, 16'h1234, 16'hedcb, 16'h8000, 16'h7fff, 16'h0001, 16'hffff},
              1'b0, 2'b11);
    send_beat(random_data(0), 1'b1, 2'b10);
    send_beat(random_data(0), 1'b1, 2'b11);
    // Long full-scale plaquette to drive large sums into the overlap lanes.
    for (int i = 0; i < 12; i++) send_beat({8{16'h8000}}, i == 11, 2'b01);
    for (int i = 0; i < 4; i++) send_beat(random_data(0), 1'b1, 2'b11);
    drain();
  endtask

  task automatic test_random(input int beats, input int idle_pct, input int stall_pct);
    int start;
    sender_idle_pct = idle_pct;
    receiver_stall_pct = stall_pct;
    start = beats_sent;
    while (beats_sent - start < beats) begin
      if ($urandom_range(9) == 0) begin
        // Noise: arbitrary flag patterns.
        send_beat(random_data(0), 1'($urandom), 2'($urandom));
      end else begin
        for (int s = 0; s < $urandom_range(1, 3); s++) send_state(s == 2);
        send_state(1'b1);
      end
    end
    drain();
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
  endtask

  // Receiver holds off while plaquettes keep arriving, so the input stalls.
  task automatic test_backpressure();
    hold_off_cycles = 400;
    for (int i = 0; i < 12; i++) send_plaquette(2, 1'b1, i == 11);
    drain();
  endtask

  task automatic test_offsets();
    logic [15:0] vals [4] = '{16'h0000, 16'hffff, 16'h8000, 16'h7fff};
    foreach (vals[i]) begin
      write_offset(vals[i]);
      for (int s = 0; s < 3; s++) send_state(s == 2);
      drain();
    end
    write_offset(16'd256);
  endtask

  // Receiver readiness and result checking.
  always @(posedge clk) begin
    chern_result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[30:0];
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_tdata);
        failures++;
      end else begin
        want = pending_results.pop_front();
        if (got !== want || out_tdata[31] !== 1'b0) begin
          $display("%0t: expected %h, actual %h", $time, want, out_tdata);
          failures++;
        end
      end
    end
    if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= (receiver_stall_pct == 0) || ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  initial begin
    for (int i = 0; i < 8; i++) overlap_sum[i] = 0;
    phase_total = 0;
    sample_total = 0;
    offset_turns = 256;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_offsets();
    test_backpressure();
    test_random(170, 0, 0);
    test_random(170, 53, 0);
    test_random(170, 0, 53);
    test_random(170, 29, 29);
    if (pending_results.size() != 0) failures++;
    if (failures == 0) begin
      $display("plaquette_berry_phase_chern_unit: match");
    end else begin
      $display("plaquette_berry_phase_chern_unit: mismatch");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("plaquette_berry_phase_chern_unit: mismatch");
    $finish;
  end
endmodule

@@ filelist.f @@
+incdir+rtl
rtl/pbc_pkg.sv
rtl/pbc_lane.sv
rtl/pbc_cordic.sv
rtl/plaquette_berry_phase_chern_unit.sv
dv/testbench.sv
